### rtl/gf2mai_pkg.sv
`default_nettype none

package gf2mai_pkg;

    // Fixed field widths of the streaming and configuration ports.
    localparam int IN_W      = 64;
    localparam int CFG_W     = 9;
    localparam int REG_IDX_W = 3;

    // Cell index width (up to 32 cells), bit position width, step counter width.
    localparam int CIDX_W = 5;
    localparam int POS_W  = 11;
    localparam int CNT_W  = 12;

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FIELD_DEGREE = 3'd0,
        REG_MIDDLE_A     = 3'd1,
        REG_MIDDLE_B     = 3'd2,
        REG_MIDDLE_C     = 3'd3,
        REG_POLY_KIND    = 3'd4
    } cfg_reg_t;

    // Operations broadcast to every cell of the chain.
    typedef enum logic [3:0] {
        OP_HOLD,
        OP_LOAD,
        OP_PREP,
        OP_CLR_G,
        OP_RED_F,
        OP_RED_B,
        OP_INIT,
        OP_HALVE,
        OP_XOR,
        OP_DIV
    } cell_op_t;

    // Control broadcast from the sequencer to the cells.
    typedef struct packed {
        cell_op_t            op;
        logic                swap;
        logic                red_hit;
        logic                b_odd;
        logic [CIDX_W-1:0]   load_idx;
        logic [IN_W-1:0]     load_word;
        logic [CFG_W-1:0]    fd;
        logic [CFG_W-1:0]    ea;
        logic [CFG_W-1:0]    eb;
        logic [CFG_W-1:0]    ec;
        logic                pent;
        logic [CFG_W-1:0]    dp;
    } cell_ctrl_t;

    // Status each cell reports about its own slice.
    typedef struct packed {
        logic f_nz;
        logic f_one;
        logic lt;
        logic any_nz;
        logic hit;
    } cell_stat_t;

endpackage

`default_nettype wire

### rtl/gf2mai_cell.sv
`default_nettype none

module gf2mai_cell
    import gf2mai_pkg::*;
#(
    parameter int WB  = 64,
    parameter int IDX = 0
)
(
    input  wire logic          clk,
    input  wire cell_ctrl_t    ctrl,
    input  wire logic          f_up_lsb,
    input  wire logic          bx_up_lsb,
    input  wire logic          f_dn_msb,
    input  wire logic          b_dn_msb,
    input  wire logic          c_dn_msb,
    input  wire logic          g_dn_msb,
    output logic               f_lsb,
    output logic               f_msb,
    output logic               b_lsb,
    output logic               bx_lsb,
    output logic               b_msb,
    output logic               c_msb,
    output logic               g_msb,
    output logic [WB-1:0]      g_word,
    output cell_stat_t         stat
);

    logic [WB-1:0] f_reg, f_next;
    logic [WB-1:0] g_reg, g_next;
    logic [WB-1:0] b_reg, b_next;
    logic [WB-1:0] c_reg, c_next;
    logic [WB-1:0] p_reg, p_next;
    logic [WB-1:0] pt_reg, pt_next;
    logic [WB-1:0] gs;
    logic [WB-1:0] bx;
    logic [WB-1:0] pdec;
    logic [WB-1:0] ptdec;

    // Shifted accumulator, B with the modulus folded in, and the modulus decode.
    always_comb
    begin
        gs = {g_reg[WB-2:0], g_dn_msb};
        bx = b_reg ^ (ctrl.b_odd ? p_reg : '0);
        for (int j = 0; j < WB; j++)
        begin
            pdec[j] = (POS_W'(IDX * WB + j) == POS_W'(ctrl.fd))
                    ^ (POS_W'(IDX * WB + j) == POS_W'(ctrl.ea))
                    ^ (ctrl.pent && (POS_W'(IDX * WB + j) == POS_W'(ctrl.eb)))
                    ^ (ctrl.pent && (POS_W'(IDX * WB + j) == POS_W'(ctrl.ec)))
                    ^ (POS_W'(IDX * WB + j) == '0);
            ptdec[j] = (POS_W'(IDX * WB + j) == POS_W'(ctrl.dp));
        end
    end

    // Next value of the slice for each broadcast operation.
    always_comb
    begin
        f_next  = f_reg;
        g_next  = g_reg;
        b_next  = b_reg;
        c_next  = c_reg;
        p_next  = p_reg;
        pt_next = pt_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
            end
            OP_LOAD:
            begin
                if (ctrl.load_idx == '0)
                begin
                    f_next = (IDX == 0) ? ctrl.load_word[WB-1:0] : '0;
                end
                else if (ctrl.load_idx == CIDX_W'(IDX))
                begin
                    f_next = ctrl.load_word[WB-1:0];
                end
            end
            OP_PREP:
            begin
                p_next  = pdec;
                pt_next = ptdec;
            end
            OP_CLR_G:
            begin
                g_next = '0;
            end
            OP_RED_F:
            begin
                g_next = gs ^ (ctrl.red_hit ? p_reg : '0);
                f_next = {f_reg[WB-2:0], f_dn_msb};
            end
            OP_RED_B:
            begin
                g_next = gs ^ (ctrl.red_hit ? p_reg : '0);
                b_next = {b_reg[WB-2:0], b_dn_msb};
            end
            OP_INIT:
            begin
                f_next = g_reg;
                g_next = p_reg;
                b_next = (IDX == 0) ? WB'(1) : '0;
                c_next = '0;
            end
            OP_HALVE:
            begin
                f_next = {f_up_lsb, f_reg[WB-1:1]};
                c_next = {c_reg[WB-2:0], c_dn_msb};
            end
            OP_XOR:
            begin
                f_next = f_reg ^ g_reg;
                b_next = b_reg ^ c_reg;
                if (ctrl.swap)
                begin
                    g_next = f_reg;
                    c_next = b_reg;
                end
            end
            OP_DIV:
            begin
                b_next = {bx_up_lsb, bx[WB-1:1]};
            end
            default:
            begin
            end
        endcase
    end

    // Slice storage.
    always_ff @(posedge clk)
    begin
        f_reg  <= f_next;
        g_reg  <= g_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        p_reg  <= p_next;
        pt_reg <= pt_next;
    end

    // Edge bits for the neighbors and local status.
    assign f_lsb  = f_reg[0];
    assign f_msb  = f_reg[WB-1];
    assign b_lsb  = b_reg[0];
    assign bx_lsb = bx[0];
    assign b_msb  = b_reg[WB-1];
    assign c_msb  = c_reg[WB-1];
    assign g_msb  = g_reg[WB-1];
    assign g_word = g_reg;

    assign stat.f_nz   = |f_reg;
    assign stat.f_one  = (f_reg == WB'(1));
    assign stat.lt     = (f_reg < g_reg) && ((f_reg ^ g_reg) > f_reg);
    assign stat.any_nz = |(f_reg | g_reg);
    assign stat.hit    = |(gs & pt_reg);

endmodule

`default_nettype wire

### rtl/gf2m_almost_inverse.sv
`default_nettype none
// Steps: the operand is reduced one bit a cycle, the GCD steps run, the result is
// divided by x^k and reduced one bit a cycle, and the result words are sent out.
// One inversion is in flight at a time; a new element is taken once the last result
// word has been transferred. Words are taken one per cycle while the block is idle.
// Reset (rst_n low, asynchronous) clears the sequencer and loads the default
// pentanomial x^163 + x^7 + x^6 + x^3 + 1; the polynomial storage is not cleared.

module gf2m_almost_inverse
    import gf2mai_pkg::*;
#(
    parameter int MAX_WORDS = 8,
    parameter int WORD_BITS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,    // operand_word
    input  wire logic                 s_tlast,    // last_word
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [IN_W-1:0]           m_tdata,    // result_word
    output logic                      m_tlast,    // result_last
    output logic                      m_tuser,    // zero_input
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int NC     = (1024 + WORD_BITS - 1) / WORD_BITS;
    localparam int TB     = NC * WORD_BITS;
    localparam int WCNT_W = $clog2(MAX_WORDS + 1);
    localparam int CSEL_W = $clog2(NC);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CHK, S_REDF, S_INIT, S_GCD, S_DIV, S_CLRG, S_REDB, S_OUT
    } state_t;

    state_t              state_reg;
    logic [WCNT_W-1:0]   load_idx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    k_reg;
    logic                poly_ok_reg;
    logic                fail_reg;
    logic [WCNT_W-1:0]   n_reg;
    logic [WCNT_W-1:0]   out_idx_reg;
    logic                out_valid_reg;
    logic [IN_W-1:0]     out_word_reg;
    logic                out_last_reg;
    logic                out_zero_reg;

    logic [CFG_W-1:0]    fd_reg, ea_reg, eb_reg, ec_reg;
    logic                kind_reg;

    cell_ctrl_t          ctrl;
    cell_stat_t          stat [NC];
    logic [WORD_BITS-1:0] g_words [NC];
    logic [NC:0]         f_lsb_v, bx_lsb_v;
    logic [NC-1:0]       b_lsb_v;
    logic [NC:0]         f_msb_v, b_msb_v, c_msb_v, g_msb_v;

    logic                s_xfer, m_xfer;
    logic                f_zero, f_one, f_less, red_hit;
    logic [CFG_W-1:0]    dp_c;
    logic                dp_has, poly_ok_c;
    logic [WCNT_W-1:0]   n_c;
    logic [CFG_W-1:0]    ex [5];
    logic [4:0]          act, odd;
    logic                par;
    logic [IN_W-1:0]     next_word;

    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = m_tvalid && m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_reg   <= CFG_W'(163);
            ea_reg   <= CFG_W'(7);
            eb_reg   <= CFG_W'(6);
            ec_reg   <= CFG_W'(3);
            kind_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIELD_DEGREE: fd_reg   <= cfg_data;
                REG_MIDDLE_A:     ea_reg   <= cfg_data;
                REG_MIDDLE_B:     eb_reg   <= cfg_data;
                REG_MIDDLE_C:     ec_reg   <= cfg_data;
                REG_POLY_KIND:    kind_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Degree of the modulus (equal exponents cancel in pairs), its validity and the result word count.
    always_comb
    begin
        ex[0] = fd_reg;
        ex[1] = ea_reg;
        ex[2] = eb_reg;
        ex[3] = ec_reg;
        ex[4] = '0;
        act   = {1'b1, kind_reg, kind_reg, 1'b1, 1'b1};
        par   = 1'b0;
        dp_c  = '0;
        dp_has = 1'b0;
        for (int t = 0; t < 5; t++)
        begin
            par = 1'b0;
            for (int u = 0; u < 5; u++)
            begin
                par = par ^ (act[u] && (ex[u] == ex[t]));
            end
            odd[t] = act[t] && par;
        end
        for (int t = 0; t < 5; t++)
        begin
            if (odd[t] && (!dp_has || (ex[t] > dp_c)))
            begin
                dp_c   = ex[t];
                dp_has = 1'b1;
            end
        end
        poly_ok_c = dp_has && (dp_c != '0) && odd[4];
        n_c = '0;
        for (int j = 0; j < MAX_WORDS; j++)
        begin
            if (dp_has && (POS_W'(j * WORD_BITS) < POS_W'(dp_c)))
            begin
                n_c = n_c + WCNT_W'(1);
            end
        end
        if (n_c == '0)
        begin
            n_c = WCNT_W'(1);
        end
    end

    // Global status gathered from the chain.
    always_comb
    begin
        f_zero  = 1'b1;
        f_one   = stat[0].f_one;
        f_less  = 1'b0;
        red_hit = 1'b0;
        for (int i = 0; i < NC; i++)
        begin
            if (stat[i].f_nz)
            begin
                f_zero = 1'b0;
            end
            if ((i != 0) && stat[i].f_nz)
            begin
                f_one = 1'b0;
            end
            if (stat[i].any_nz)
            begin
                f_less = stat[i].lt;
            end
            red_hit = red_hit | stat[i].hit;
        end
    end

    // Operation broadcast to the cells.
    always_comb
    begin
        ctrl.op        = OP_HOLD;
        ctrl.swap      = f_less;
        ctrl.red_hit   = red_hit;
        ctrl.b_odd     = b_lsb_v[0];
        ctrl.load_idx  = CIDX_W'(load_idx_reg);
        ctrl.load_word = s_tdata;
        ctrl.fd        = fd_reg;
        ctrl.ea        = ea_reg;
        ctrl.eb        = eb_reg;
        ctrl.ec        = ec_reg;
        ctrl.pent      = kind_reg;
        ctrl.dp        = dp_c;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_xfer && (load_idx_reg < WCNT_W'(MAX_WORDS)))
                begin
                    ctrl.op = OP_LOAD;
                end
            end
            S_PREP: ctrl.op = OP_PREP;
            S_CHK:  ctrl.op = poly_ok_reg ? OP_CLR_G : OP_HOLD;
            S_REDF: ctrl.op = OP_RED_F;
            S_INIT: ctrl.op = OP_INIT;
            S_GCD:
            begin
                if (f_zero)
                begin
                    ctrl.op = OP_HOLD;
                end
                else if (!f_lsb_v[0])
                begin
                    ctrl.op = OP_HALVE;
                end
                else if (f_one)
                begin
                    ctrl.op = OP_HOLD;
                end
                else
                begin
                    ctrl.op = OP_XOR;
                end
            end
            S_DIV:  ctrl.op = (cnt_reg != k_reg) ? OP_DIV : OP_HOLD;
            S_CLRG: ctrl.op = OP_CLR_G;
            S_REDB: ctrl.op = OP_RED_B;
            S_OUT:  ctrl.op = OP_HOLD;
            default: ctrl.op = OP_HOLD;
        endcase
    end

    // Chain edges: bits entering from beyond either end.
    assign f_lsb_v[NC]  = 1'b0;
    assign bx_lsb_v[NC] = 1'b0;
    assign f_msb_v[0]   = 1'b0;
    assign b_msb_v[0]   = 1'b0;
    assign c_msb_v[0]   = 1'b0;
    assign g_msb_v[0]   = (state_reg == S_REDB) ? b_msb_v[NC] : f_msb_v[NC];

    // The row of cells.
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        gf2mai_cell #(
            .WB  (WORD_BITS),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .f_up_lsb  (f_lsb_v[i+1]),
            .bx_up_lsb (bx_lsb_v[i+1]),
            .f_dn_msb  (f_msb_v[i]),
            .b_dn_msb  (b_msb_v[i]),
            .c_dn_msb  (c_msb_v[i]),
            .g_dn_msb  (g_msb_v[i]),
            .f_lsb     (f_lsb_v[i]),
            .f_msb     (f_msb_v[i+1]),
            .b_lsb     (b_lsb_v[i]),
            .bx_lsb    (bx_lsb_v[i]),
            .b_msb     (b_msb_v[i+1]),
            .c_msb     (c_msb_v[i+1]),
            .g_msb     (g_msb_v[i+1]),
            .g_word    (g_words[i]),
            .stat      (stat[i])
        );
    end

    // Word following the one on the output.
    assign next_word = fail_reg ? '0
                     : IN_W'(g_words[CSEL_W'(out_idx_reg + WCNT_W'(1))]);

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_idx_reg  <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            poly_ok_reg   <= 1'b0;
            fail_reg      <= 1'b0;
            n_reg         <= WCNT_W'(1);
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_zero_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_xfer)
                    begin
                        if (load_idx_reg < WCNT_W'(MAX_WORDS))
                        begin
                            load_idx_reg <= load_idx_reg + WCNT_W'(1);
                        end
                        if (s_tlast)
                        begin
                            load_idx_reg <= '0;
                            state_reg    <= S_PREP;
                        end
                    end
                end
                S_PREP:
                begin
                    poly_ok_reg <= poly_ok_c;
                    n_reg       <= n_c;
                    fail_reg    <= 1'b0;
                    state_reg   <= S_CHK;
                end
                S_CHK:
                begin
                    cnt_reg <= '0;
                    if (poly_ok_reg)
                    begin
                        state_reg <= S_REDF;
                    end
                    else
                    begin
                        fail_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_REDF:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(TB - 1))
                    begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    k_reg     <= '0;
                    state_reg <= S_GCD;
                end
                S_GCD:
                begin
                    if (f_zero)
                    begin
                        fail_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (!f_lsb_v[0])
                    begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                    else if (f_one)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg != k_reg)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_CLRG;
                    end
                end
                S_CLRG:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_REDB;
                end
                S_REDB:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(TB - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // First word is loaded on entry, later ones on each transfer.
                    if (!out_valid_reg)
                    begin
                        out_idx_reg   <= '0;
                        out_valid_reg <= 1'b1;
                        out_word_reg  <= fail_reg ? '0 : IN_W'(g_words[0]);
                        out_last_reg  <= (n_reg == WCNT_W'(1));
                        out_zero_reg  <= fail_reg;
                    end
                    else if (m_xfer)
                    begin
                        if (out_last_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            out_idx_reg  <= out_idx_reg + WCNT_W'(1);
                            out_word_reg <= next_word;
                            out_last_reg <= (out_idx_reg + WCNT_W'(2) == n_reg);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_zero_reg;

endmodule

`default_nettype wire

### bench/gf2m_almost_inverse_checker.sv
`timescale 1ns / 1ps

module gf2m_almost_inverse_checker
    import gf2mai_pkg::*;
#(
    parameter int MAX_WORDS = 8,
    parameter int WORD_BITS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [IN_W-1:0]      m_tdata,
    input  wire logic                 m_tlast,
    input  wire logic                 m_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output int                        errors,
    output int                        pending
);

    localparam int PBITS = 1024;

    typedef logic [PBITS-1:0] gf_poly_t;

    typedef struct {
        logic [IN_W-1:0] word;
        logic            last;
        logic            zero;
    } inv_word_t;

    inv_word_t       inverse_q[$];
    gf_poly_t        operand;
    int              words_loaded;
    logic [CFG_W-1:0] deg_m;
    logic [CFG_W-1:0] exp_a;
    logic [CFG_W-1:0] exp_b;
    logic [CFG_W-1:0] exp_c;
    logic            is_pent;

    function automatic int poly_degree(gf_poly_t p);
        for (int i = PBITS - 1; i >= 0; i--)
        begin
            if (p[i])
                return i;
        end
        return -1;
    endfunction

    function automatic gf_poly_t mod_reduce(gf_poly_t p, gf_poly_t modulus, int dp);
        for (int i = PBITS - 1; i >= dp; i--)
        begin
            if (p[i])
                p = p ^ (modulus << (i - dp));
        end
        return p;
    endfunction

    // Almost-inverse GCD followed by division by x^k; returns 0 when no inverse exists.
    function automatic bit field_inverse(gf_poly_t elem, gf_poly_t modulus, int dp,
                                         output gf_poly_t inv);
        gf_poly_t f, g, b, c, t;
        int       k;
        inv = '0;
        if (dp < 1 || !modulus[0])
            return 0;
        f = mod_reduce(elem, modulus, dp);
        if (f == '0)
            return 0;
        g = modulus;
        b = gf_poly_t'(1);
        c = '0;
        k = 0;
        forever
        begin
            while (!f[0])
            begin
                f = f >> 1;
                c = c << 1;
                k++;
            end
            if (f == gf_poly_t'(1))
                break;
            if (poly_degree(f) < poly_degree(g))
            begin
                t = f; f = g; g = t;
                t = b; b = c; c = t;
            end
            f = f ^ g;
            b = b ^ c;
            if (f == '0)
                return 0;
        end
        for (int n = 0; n < k; n++)
        begin
            if (b[0])
                b = b ^ modulus;
            b = b >> 1;
        end
        inv = mod_reduce(b, modulus, dp);
        return 1;
    endfunction

    // Queue the words of the inverse for the element collected so far.
    task automatic predict_inverse();
        gf_poly_t  modulus, inv;
        int        dp, n;
        bit        ok;
        inv_word_t w;
        modulus = '0;
        modulus[deg_m] = ~modulus[deg_m];
        modulus[exp_a] = ~modulus[exp_a];
        if (is_pent)
        begin
            modulus[exp_b] = ~modulus[exp_b];
            modulus[exp_c] = ~modulus[exp_c];
        end
        modulus[0] = ~modulus[0];
        dp = poly_degree(modulus);
        ok = field_inverse(operand, modulus, dp, inv);
        n = (dp >= 1) ? (dp + WORD_BITS - 1) / WORD_BITS : 1;
        if (n > MAX_WORDS)
            n = MAX_WORDS;
        for (int j = 0; j < n; j++)
        begin
            w.word = '0;
            if (ok)
                w.word[WORD_BITS-1:0] = inv[j*WORD_BITS +: WORD_BITS];
            w.last = (j == n - 1);
            w.zero = !ok;
            inverse_q.push_back(w);
        end
    endtask

    // Track configuration, collect operand words and check result words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_m        <= 9'd163;
            exp_a        <= 9'd7;
            exp_b        <= 9'd6;
            exp_c        <= 9'd3;
            is_pent      <= 1'b1;
            words_loaded = 0;
            operand      = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FIELD_DEGREE: deg_m   <= cfg_data;
                    REG_MIDDLE_A:     exp_a   <= cfg_data;
                    REG_MIDDLE_B:     exp_b   <= cfg_data;
                    REG_MIDDLE_C:     exp_c   <= cfg_data;
                    REG_POLY_KIND:    is_pent <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (words_loaded == 0)
                    operand = '0;
                if (words_loaded < MAX_WORDS)
                begin
                    operand[words_loaded*WORD_BITS +: WORD_BITS] ^= s_tdata[WORD_BITS-1:0];
                    words_loaded++;
                end
                if (s_tlast)
                begin
                    words_loaded = 0;
                    predict_inverse();
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected result word %h last %b zero %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    errors++;
                end
                else
                begin
                    inv_word_t w;
                    w = inverse_q.pop_front();
                    if (m_tdata !== w.word || m_tlast !== w.last || m_tuser !== w.zero)
                    begin
                        $display("%0t: expected word %h last %b zero %b, got %h %b %b",
                                 $time, w.word, w.last, w.zero, m_tdata, m_tlast, m_tuser);
                        errors++;
                    end
                end
            end
        end
        pending = inverse_q.size();
    end

    initial
    begin
        errors  = 0;
        pending = 0;
    end

endmodule

### bench/gf2m_almost_inverse_tb.sv
`timescale 1ns / 1ps

module gf2m_almost_inverse_tb;
    import gf2mai_pkg::*;

    localparam int  NUM_PHASES  = 10;
    localparam int  SETTLE      = 40;
    localparam longint LIMIT    = 6000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;     // operand_word
    logic                 s_tlast = 1'b0;   // last_word
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [IN_W-1:0]      m_tdata;          // result_word
    logic                 m_tlast;          // result_last
    logic                 m_tuser;          // zero_input
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int     errors;
    int     pending;
    bit     quiet = 1'b0;
    int     sink_stall = 0;
    longint cycles = 0;

    // Field settings per phase: degree, a, b, c, pentanomial flag.
    int field_set[NUM_PHASES][5] = '{
        '{163, 7, 6, 3, 1},
        '{2, 1, 1, 1, 0},
        '{511, 510, 509, 1, 1},
        '{233, 74, 1, 1, 0},
        '{4, 2, 1, 1, 0},
        '{10, 10, 5, 5, 1},
        '{8, 9, 2, 3, 0},
        '{64, 4, 3, 1, 1},
        '{65, 18, 1, 1, 0},
        '{131, 8, 3, 2, 1}
    };

    always #5 clk = ~clk;

    gf2m_almost_inverse dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    gf2m_almost_inverse_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // Mostly no gap or a short one, a few long idle gaps, none in quiet phases.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side stalls at random.
    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            sink_stall <= idle_len();
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One operand word transfer; valid stays high into the next word when no gap follows.
    task automatic send_word(logic [IN_W-1:0] word, logic last);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the operand side until every expected result word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return {$urandom, $urandom};
        if (r < 8)
            return 64'd1 << $urandom_range(0, 63);
        if (r < 9)
            return '0;
        return '1;
    endfunction

    // One element of random length; mostly within the operand capacity.
    task automatic send_element();
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_word(rand_word(), i == len - 1);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed elements under the reset modulus.
        send_word(64'd0, 1'b1);
        send_word(64'd1, 1'b1);
        send_word(64'd2, 1'b1);
        send_word('1, 1'b1);
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h0, 1'b1);
        // The modulus itself reduces to zero.
        send_word(64'hC9, 1'b0);
        send_word(64'h0, 1'b0);
        send_word(64'h8_0000_0000, 1'b1);
        // Words beyond the capacity are dropped.
        for (int i = 0; i < 10; i++)
            send_word(64'hA5A5_5A5A_0F0F_F0F0 ^ i, i == 9);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiet = (p % 4 == 3);
            write_reg(REG_FIELD_DEGREE, field_set[p][0]);
            write_reg(REG_MIDDLE_A, field_set[p][1]);
            write_reg(REG_MIDDLE_B, field_set[p][2]);
            write_reg(REG_MIDDLE_C, field_set[p][3]);
            write_reg(REG_POLY_KIND, field_set[p][4]);
            send_word(64'd0, 1'b1);
            send_word(64'd1, 1'b1);
            for (int e = 0; e < 6; e++)
                send_element();
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
